[hw/rtl/pylex_pkg.sv]
// shared widths, token codes, character codes and record types of the lexer
package pylex_pkg;

	localparam int LINE_BITS     = 16;
	localparam int POSITION_BITS = 24;
	localparam int LENGTH_BITS   = 8;
	localparam int KIND_BITS     = 5;
	localparam int PREFIX_LEN    = 5;
	localparam int PFX_IDX_BITS  = $clog2(PREFIX_LEN);
	localparam int MAX_TOKENS    = 4;
	localparam int TOK_IDX_BITS  = $clog2(MAX_TOKENS);
	localparam int TOK_CNT_BITS  = $clog2(MAX_TOKENS + 1);
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
	localparam int NUM_KW        = 8;

	localparam logic [LINE_BITS-1:0]     LINE_TOP = {LINE_BITS{1'b1}};
	localparam logic [POSITION_BITS-1:0] POS_TOP  = {POSITION_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0]   LEN_TOP  = {LENGTH_BITS{1'b1}};

	// token kinds
	localparam logic [KIND_BITS-1:0] KIND_NEWLINE = 5'd0;
	localparam logic [KIND_BITS-1:0] KIND_IDENT   = 5'd1;
	localparam logic [KIND_BITS-1:0] KIND_NUM     = 5'd2;
	localparam logic [KIND_BITS-1:0] KIND_TRUE    = 5'd3;
	localparam logic [KIND_BITS-1:0] KIND_FALSE   = 5'd4;
	localparam logic [KIND_BITS-1:0] KIND_PRINT   = 5'd5;
	localparam logic [KIND_BITS-1:0] KIND_IF      = 5'd6;
	localparam logic [KIND_BITS-1:0] KIND_ELSE    = 5'd7;
	localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 5'd8;
	localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 5'd9;
	localparam logic [KIND_BITS-1:0] KIND_AND     = 5'd10;
	localparam logic [KIND_BITS-1:0] KIND_OR      = 5'd11;
	localparam logic [KIND_BITS-1:0] KIND_NOT     = 5'd12;
	localparam logic [KIND_BITS-1:0] KIND_ASSIGN  = 5'd13;
	localparam logic [KIND_BITS-1:0] KIND_COLON   = 5'd14;
	localparam logic [KIND_BITS-1:0] KIND_EQEQ    = 5'd15;
	localparam logic [KIND_BITS-1:0] KIND_GE      = 5'd16;
	localparam logic [KIND_BITS-1:0] KIND_LE      = 5'd17;
	localparam logic [KIND_BITS-1:0] KIND_NE      = 5'd18;
	localparam logic [KIND_BITS-1:0] KIND_LT      = 5'd19;
	localparam logic [KIND_BITS-1:0] KIND_GT      = 5'd20;
	localparam logic [KIND_BITS-1:0] KIND_PLUS    = 5'd21;
	localparam logic [KIND_BITS-1:0] KIND_MINUS   = 5'd22;
	localparam logic [KIND_BITS-1:0] KIND_STAR    = 5'd23;
	localparam logic [KIND_BITS-1:0] KIND_SLASH   = 5'd24;
	localparam logic [KIND_BITS-1:0] KIND_EOF     = 5'd25;

	// held operator codes
	localparam logic [2:0] PEND_NONE = 3'd0;
	localparam logic [2:0] PEND_EQ   = 3'd1;
	localparam logic [2:0] PEND_LT   = 3'd2;
	localparam logic [2:0] PEND_GT   = 3'd3;
	localparam logic [2:0] PEND_BANG = 3'd4;

	// character codes
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;

	// keywords, first character in the low byte, unused bytes zero
	localparam logic [PREFIX_LEN-1:0][7:0] KW_TEXT [NUM_KW] = '{
		{8'h00, "e", "u", "r", "T"},
		{"e", "s", "l", "a", "F"},
		{"t", "n", "i", "r", "p"},
		{24'h000000, "f", "i"},
		{8'h00, "e", "s", "l", "e"},
		{16'h0000, "d", "n", "a"},
		{24'h000000, "r", "o"},
		{16'h0000, "t", "o", "n"}
	};
	localparam logic [LENGTH_BITS-1:0] KW_LEN [NUM_KW] = '{
		LENGTH_BITS'(4), LENGTH_BITS'(5), LENGTH_BITS'(5), LENGTH_BITS'(2),
		LENGTH_BITS'(4), LENGTH_BITS'(3), LENGTH_BITS'(2), LENGTH_BITS'(3)
	};
	localparam logic [KIND_BITS-1:0] KW_KIND [NUM_KW] = '{
		KIND_TRUE, KIND_FALSE, KIND_PRINT, KIND_IF,
		KIND_ELSE, KIND_AND, KIND_OR, KIND_NOT
	};

	typedef struct packed {
		logic [KIND_BITS-1:0]     kind;
		logic [LINE_BITS-1:0]     line;
		logic [POSITION_BITS-1:0] start;
		logic [LENGTH_BITS-1:0]   length;
		logic                     ovf;
	} token_t;

	// all tokens caused by one source byte
	typedef struct packed {
		token_t [MAX_TOKENS-1:0]   tok;
		logic [TOK_CNT_BITS-1:0]   count;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[hw/rtl/pylex_front.sv]
// lexer front: takes source bytes, keeps the scan state, builds one token bundle per byte
module pylex_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    source_byte,
	input  logic                          end_of_source,
	input  pylex_pkg::q_stat_t            stat,
	output logic                          push,
	output pylex_pkg::bundle_t            bundle
);
	import pylex_pkg::*;

	typedef struct packed {
		logic [PREFIX_LEN-1:0][7:0]   prefix;
		logic [LENGTH_BITS-1:0]       len;
		logic [POSITION_BITS-1:0]     start;
		logic                         ovf;
	} word_t;

	function automatic word_t word_add(input word_t w, input logic [7:0] ch,
			input logic [POSITION_BITS-1:0] pos);
		word_t r;
		r = w;
		if (w.len == '0) r.start = pos;
		if (w.len < LENGTH_BITS'(PREFIX_LEN)) r.prefix[w.len[PFX_IDX_BITS-1:0]] = ch;
		if (w.len != LEN_TOP) r.len = w.len + 1'b1;
		else r.ovf = 1'b1;
		return r;
	endfunction

	function automatic void emit(inout bundle_t bd, input logic [KIND_BITS-1:0] kind,
			input logic [LINE_BITS-1:0] line, input logic [POSITION_BITS-1:0] start,
			input logic [LENGTH_BITS-1:0] len, input logic ovf);
		if (bd.count < TOK_CNT_BITS'(MAX_TOKENS)) begin
			bd.tok[bd.count[TOK_IDX_BITS-1:0]] = '{kind, line, start, len, ovf};
			bd.count = bd.count + 1'b1;
		end
	endfunction

	// keyword, number, identifier, or nothing for a word with an odd first character
	function automatic void flush(input logic [LINE_BITS-1:0] line, inout bundle_t bd,
			inout word_t w);
		logic                 hit;
		logic [KIND_BITS-1:0] kind;
		logic [7:0]           c0;
		hit  = 1'b0;
		kind = KIND_IDENT;
		c0   = w.prefix[0];
		if (!w.ovf) begin
			for (int i = 0; i < NUM_KW; i++) begin
				if (w.len == KW_LEN[i] && w.prefix == KW_TEXT[i]) begin
					hit  = 1'b1;
					kind = KW_KIND[i];
				end
			end
		end
		if (!hit) begin
			if (c0 inside {[CH_0:CH_9]}) begin
				hit  = 1'b1;
				kind = KIND_NUM;
			end else if (c0 inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ], CH_USCORE}) begin
				hit  = 1'b1;
				kind = KIND_IDENT;
			end
		end
		if (w.len != '0 && hit) emit(bd, kind, line, w.start, w.len, w.ovf);
		w = '0;
	endfunction

	// a held operator that is not followed by '='
	function automatic void resolve(input logic [2:0] pend,
			input logic [POSITION_BITS-1:0] pos, input logic [LINE_BITS-1:0] line,
			inout bundle_t bd, inout word_t w);
		case (pend)
			PEND_EQ:   emit(bd, KIND_ASSIGN, line, pos, LENGTH_BITS'(1), 1'b0);
			PEND_LT:   emit(bd, KIND_LT, line, pos, LENGTH_BITS'(1), 1'b0);
			PEND_GT:   emit(bd, KIND_GT, line, pos, LENGTH_BITS'(1), 1'b0);
			PEND_BANG: w = word_add(w, CH_BANG, pos);
			default: ;
		endcase
	endfunction

	logic [LINE_BITS-1:0]     line_q,  line_c;
	logic [POSITION_BITS-1:0] pos_q,   pos_c, prev_c;
	word_t                    word_q,  word_c;
	logic [2:0]               pend_q,  pend_c;
	logic                     cmt_q,   cmt_c;
	logic                     consumed_c;
	bundle_t                  bd_c;
	logic                     accept;

	assign in_ready = !stat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (bd_c.count != '0);
	assign bundle   = bd_c;

	always_comb begin
		line_c     = line_q;
		word_c     = word_q;
		pend_c     = pend_q;
		cmt_c      = cmt_q;
		bd_c       = '0;
		consumed_c = 1'b0;
		prev_c     = (pos_q != '0) ? pos_q - 1'b1 : pos_q;

		// the held operator is settled by this byte
		if (pend_c != PEND_NONE) begin
			if (source_byte == CH_EQ) begin
				case (pend_c)
					PEND_EQ: emit(bd_c, KIND_EQEQ, line_c, prev_c, LENGTH_BITS'(2), 1'b0);
					PEND_GT: emit(bd_c, KIND_GE, line_c, prev_c, LENGTH_BITS'(2), 1'b0);
					PEND_LT: emit(bd_c, KIND_LE, line_c, prev_c, LENGTH_BITS'(2), 1'b0);
					default: begin
						flush(line_c, bd_c, word_c);
						emit(bd_c, KIND_NE, line_c, prev_c, LENGTH_BITS'(2), 1'b0);
					end
				endcase
				consumed_c = 1'b1;
			end else begin
				resolve(pend_c, prev_c, line_c, bd_c, word_c);
			end
			pend_c = PEND_NONE;
		end

		if (!consumed_c && cmt_c && source_byte != CH_NL) consumed_c = 1'b1;

		if (!consumed_c) begin
			if (source_byte == CH_NL) cmt_c = 1'b0;
			if (source_byte inside {CH_SPACE, CH_TAB, CH_NL, CH_EQ, CH_LPAREN, CH_RPAREN,
					CH_COLON, CH_LT, CH_GT, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
					CH_HASH}) begin
				flush(line_c, bd_c, word_c);
			end
			case (source_byte)
				CH_HASH:   cmt_c = 1'b1;
				CH_COLON:  emit(bd_c, KIND_COLON, line_c, pos_q, LENGTH_BITS'(1), 1'b0);
				CH_LPAREN: emit(bd_c, KIND_LPAREN, line_c, pos_q, LENGTH_BITS'(1), 1'b0);
				CH_RPAREN: emit(bd_c, KIND_RPAREN, line_c, pos_q, LENGTH_BITS'(1), 1'b0);
				CH_PLUS:   emit(bd_c, KIND_PLUS, line_c, pos_q, LENGTH_BITS'(1), 1'b0);
				CH_MINUS:  emit(bd_c, KIND_MINUS, line_c, pos_q, LENGTH_BITS'(1), 1'b0);
				CH_STAR:   emit(bd_c, KIND_STAR, line_c, pos_q, LENGTH_BITS'(1), 1'b0);
				CH_SLASH:  emit(bd_c, KIND_SLASH, line_c, pos_q, LENGTH_BITS'(1), 1'b0);
				CH_EQ:     pend_c = PEND_EQ;
				CH_LT:     pend_c = PEND_LT;
				CH_GT:     pend_c = PEND_GT;
				CH_BANG:   pend_c = PEND_BANG;
				CH_NL: begin
					emit(bd_c, KIND_NEWLINE, line_c, pos_q, LENGTH_BITS'(1), 1'b0);
					if (line_c != LINE_TOP) line_c = line_c + 1'b1;
				end
				CH_SPACE, CH_TAB: ;
				default: word_c = word_add(word_c, source_byte, pos_q);
			endcase
		end

		pos_c = (pos_q != POS_TOP) ? pos_q + 1'b1 : pos_q;

		// final byte: settle everything, report end of file, back to reset state
		if (end_of_source) begin
			resolve(pend_c, pos_q, line_c, bd_c, word_c);
			flush(line_c, bd_c, word_c);
			emit(bd_c, KIND_EOF, line_c, pos_c, '0, 1'b0);
			line_c = LINE_BITS'(1);
			pos_c  = '0;
			word_c = '0;
			pend_c = PEND_NONE;
			cmt_c  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= LINE_BITS'(1);
			pos_q  <= '0;
			word_q <= '0;
			pend_q <= PEND_NONE;
			cmt_q  <= 1'b0;
		end else if (accept) begin
			line_q <= line_c;
			pos_q  <= pos_c;
			word_q <= word_c;
			pend_q <= pend_c;
			cmt_q  <= cmt_c;
		end
	end

endmodule

[hw/rtl/pylex_queue.sv]
// short queue of token bundles between lexer front and token back end
module pylex_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pylex_pkg::bundle_t   wdata,
	input  logic                 pop,
	output pylex_pkg::bundle_t   head,
	output pylex_pkg::q_stat_t   stat
);
	import pylex_pkg::*;

	bundle_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]  wr_q, rd_q;
	logic [QCNT_BITS-1:0]  cnt_q;

	assign head       = slot_q[rd_q];
	assign stat.full  = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hw/rtl/pylex_back.sv]
// token back end: walks the head bundle one token per cycle into the output register, unless out_ready stalls it
module pylex_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pylex_pkg::bundle_t   head,
	input  pylex_pkg::q_stat_t   stat,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pylex_pkg::token_t    tok,
	output logic                 last
);
	import pylex_pkg::*;

	logic [TOK_IDX_BITS-1:0] idx_q;
	logic                    valid_q;
	token_t                  tok_q;
	logic                    last_q;
	logic                    load;
	logic                    at_end;

	assign load      = !stat.empty && (!valid_q || out_ready);
	assign at_end    = ({1'b0, idx_q} + 1'b1) == head.count;
	assign pop       = load && at_end;
	assign out_valid = valid_q;
	assign tok       = tok_q;
	assign last      = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= head.tok[idx_q];
			last_q <= at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? '0 : idx_q + 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/python_subset_lexer.sv]
// top level of the streaming lexer for a small python subset
//
//  channel | direction | beat                                   | handshake
//  --------+-----------+----------------------------------------+--------------------
//  in      | sink      | source_byte, end_of_source             | in_valid / in_ready
//  out     | source    | token_kind, line_number, start_offset, | out_valid / out_ready
//          |           | token_length, word_overflow, last_token|
//
// one source byte is taken per cycle while the bundle queue has a free slot
// each byte yields zero to three tokens in a single cycle of front logic
// the back end drains one token per cycle unless out_ready stalls it
// the four-slot queue between the two rides out bursts and stalls on either side
// async reset: line 1, position 0, empty word, nothing held, no comment, queue empty
module python_subset_lexer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          source_byte,
	input  logic                                end_of_source,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pylex_pkg::KIND_BITS-1:0]     token_kind,
	output logic [pylex_pkg::LINE_BITS-1:0]     line_number,
	output logic [pylex_pkg::POSITION_BITS-1:0] start_offset,
	output logic [pylex_pkg::LENGTH_BITS-1:0]   token_length,
	output logic                                word_overflow,
	output logic                                last_token
);
	import pylex_pkg::*;

	// front to queue
	bundle_t  fr_bundle;
	logic     fr_push;
	// queue to back end
	bundle_t  q_head;
	q_stat_t  q_stat;
	logic     bk_pop;
	token_t   bk_tok;

	// scanning: word building, keyword match, held operator, comment skip
	pylex_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.source_byte   (source_byte),
		.end_of_source (end_of_source),
		.stat          (q_stat),
		.push          (fr_push),
		.bundle        (fr_bundle)
	);

	// bundles wait here; empty bytes never take a slot
	pylex_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_push),
		.wdata  (fr_bundle),
		.pop    (bk_pop),
		.head   (q_head),
		.stat   (q_stat)
	);

	// serializer with the output register, last_token marks a bundle's final token
	pylex_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.stat      (q_stat),
		.pop       (bk_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tok       (bk_tok),
		.last      (last_token)
	);

	assign token_kind    = bk_tok.kind;
	assign line_number   = bk_tok.line;
	assign start_offset  = bk_tok.start;
	assign token_length  = bk_tok.length;
	assign word_overflow = bk_tok.ovf;

endmodule

[hw/rtl/pylex_checker.sv]
// port-level checks on the lexer's token output, bound to the top level
module pylex_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [pylex_pkg::KIND_BITS-1:0]     token_kind,
	input logic [pylex_pkg::LINE_BITS-1:0]     line_number,
	input logic [pylex_pkg::POSITION_BITS-1:0] start_offset,
	input logic [pylex_pkg::LENGTH_BITS-1:0]   token_length,
	input logic                                word_overflow,
	input logic                                last_token
);
	import pylex_pkg::*;

	// a stalled token beat keeps its kind, line, start and length
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind)
			&& $stable(line_number) && $stable(start_offset) && $stable(token_length))
		else $error("token beat changed while stalled");

	// end of file closes its byte's bundle, with empty length
	a_eof_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_EOF |-> last_token && token_length == '0
			&& !word_overflow)
		else $error("malformed end of file token");

	// overflow only on a saturated number or identifier
	a_ovf_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && word_overflow |-> token_length == LEN_TOP
			&& (token_kind == KIND_IDENT || token_kind == KIND_NUM))
		else $error("overflow flag on a token that is not a full word");

	// two-character operators span two bytes
	a_dbl_op: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == KIND_EQEQ || token_kind == KIND_GE
			|| token_kind == KIND_LE || token_kind == KIND_NE)
			|-> token_length == LENGTH_BITS'(2) && !word_overflow)
		else $error("two-character operator with wrong length");

endmodule

bind python_subset_lexer pylex_checker u_pylex_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.token_kind    (token_kind),
	.line_number   (line_number),
	.start_offset  (start_offset),
	.token_length  (token_length),
	.word_overflow (word_overflow),
	.last_token    (last_token)
);

[bench/python_subset_lexer_tb.sv]
// self-checking bench of the python subset lexer: byte driver, token monitor and lexer predictor
module python_subset_lexer_tb;
	import pylex_pkg::*;

	localparam int STALL_PCT     = 23;
	localparam int IDLE_LIMIT    = 2000;
	localparam int DRAIN_CYCLES  = 24;
	localparam int RANDOM_BYTES  = 60;
	localparam int LONG_WORD_LEN = 258;
	localparam int QUIET_FROM    = 100;
	localparam int QUIET_TO      = 250;

	typedef struct packed {
		logic [7:0] data;
		logic       eos;
	} source_beat_t;

	typedef struct packed {
		token_t tok;
		logic   last;
	} lexeme_t;

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     in_valid      = 1'b0;
	logic                     in_ready;
	logic [7:0]               source_byte   = '0;
	logic                     end_of_source = 1'b0;
	logic                     out_valid;
	logic                     out_ready     = 1'b0;
	logic [KIND_BITS-1:0]     token_kind;
	logic [LINE_BITS-1:0]     line_number;
	logic [POSITION_BITS-1:0] start_offset;
	logic [LENGTH_BITS-1:0]   token_length;
	logic                     word_overflow;
	logic                     last_token;

	python_subset_lexer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.source_byte   (source_byte),
		.end_of_source (end_of_source),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.token_kind    (token_kind),
		.line_number   (line_number),
		.start_offset  (start_offset),
		.token_length  (token_length),
		.word_overflow (word_overflow),
		.last_token    (last_token)
	);

	always #1 clk = ~clk;

	// pending byte beats and the tokens they are predicted to yield
	source_beat_t source_beats [$];
	lexeme_t      expected_tokens [$];
	logic [7:0]   text_buf [$];

	source_beat_t next_beat;
	lexeme_t      want;
	logic         in_beat_done = 1'b0;
	int           cycle_count  = 0;
	int           idle_cycles  = 0;
	int           fail_count   = 0;
	logic         quiet;

	// a window of cycles in which neither side stalls
	assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

	// lexer state as the predictor tracks it
	logic [LINE_BITS-1:0]     line_cnt;
	logic [POSITION_BITS-1:0] byte_pos;
	logic [7:0]               prefix [PREFIX_LEN];
	logic [LENGTH_BITS-1:0]   word_len;
	logic [POSITION_BITS-1:0] word_begin;
	logic                     word_ovf;
	logic [2:0]               held_op;
	logic                     in_comment;
	lexeme_t                  step_tokens [MAX_TOKENS];
	int                       step_count;

	task automatic clear_word();
		int i;
		for (i = 0; i < PREFIX_LEN; i++) prefix[i] = '0;
		word_len   = '0;
		word_begin = '0;
		word_ovf   = 1'b0;
	endtask

	task automatic clear_lexer();
		line_cnt   = LINE_BITS'(1);
		byte_pos   = '0;
		held_op    = PEND_NONE;
		in_comment = 1'b0;
		clear_word();
	endtask

	// tokens of one byte are collected first so the last one can be marked
	task automatic note_token(input logic [KIND_BITS-1:0] kind,
			input logic [POSITION_BITS-1:0] start, input logic [LENGTH_BITS-1:0] len,
			input logic ovf);
		lexeme_t t;
		if (step_count < MAX_TOKENS) begin
			t.tok.kind   = kind;
			t.tok.line   = line_cnt;
			t.tok.start  = start;
			t.tok.length = len;
			t.tok.ovf    = ovf;
			t.last       = 1'b0;
			step_tokens[step_count] = t;
			step_count++;
		end
	endtask

	task automatic add_char(input logic [7:0] ch, input logic [POSITION_BITS-1:0] pos);
		if (word_len == '0) word_begin = pos;
		if (word_len < PREFIX_LEN) prefix[word_len[PFX_IDX_BITS-1:0]] = ch;
		if (word_len != LEN_TOP) word_len = word_len + 1'b1;
		else word_ovf = 1'b1;
	endtask

	// keyword, number or identifier; words led by anything else vanish
	task automatic flush_word();
		logic [39:0]          w;
		logic [KIND_BITS-1:0] kind;
		logic                 hit;
		logic [7:0]           c0;
		if (word_len != '0) begin
			w    = {prefix[0], prefix[1], prefix[2], prefix[3], prefix[4]};
			c0   = prefix[0];
			hit  = 1'b1;
			kind = KIND_IDENT;
			if (word_ovf) hit = 1'b0;
			else case (word_len)
				LENGTH_BITS'(2): if (w[39:24] == "if") kind = KIND_IF;
					else if (w[39:24] == "or") kind = KIND_OR;
					else hit = 1'b0;
				LENGTH_BITS'(3): if (w[39:16] == "and") kind = KIND_AND;
					else if (w[39:16] == "not") kind = KIND_NOT;
					else hit = 1'b0;
				LENGTH_BITS'(4): if (w[39:8] == "True") kind = KIND_TRUE;
					else if (w[39:8] == "else") kind = KIND_ELSE;
					else hit = 1'b0;
				LENGTH_BITS'(5): if (w == "False") kind = KIND_FALSE;
					else if (w == "print") kind = KIND_PRINT;
					else hit = 1'b0;
				default: hit = 1'b0;
			endcase
			if (!hit) begin
				if (c0 >= CH_0 && c0 <= CH_9) begin
					kind = KIND_NUM;
					hit  = 1'b1;
				end else if ((c0 >= CH_LA && c0 <= CH_LZ) || (c0 >= CH_UA && c0 <= CH_UZ) ||
						c0 == CH_USCORE) begin
					kind = KIND_IDENT;
					hit  = 1'b1;
				end
			end
			if (hit) note_token(kind, word_begin, word_len, word_ovf);
			clear_word();
		end
	endtask

	// a held operator not followed by '=' stands alone; a lone '!' joins the word
	task automatic resolve_held(input logic [POSITION_BITS-1:0] pos);
		case (held_op)
			PEND_EQ:   note_token(KIND_ASSIGN, pos, LENGTH_BITS'(1), 1'b0);
			PEND_LT:   note_token(KIND_LT, pos, LENGTH_BITS'(1), 1'b0);
			PEND_GT:   note_token(KIND_GT, pos, LENGTH_BITS'(1), 1'b0);
			PEND_BANG: add_char(CH_BANG, pos);
			default: ;
		endcase
		held_op = PEND_NONE;
	endtask

	// tokens caused by one accepted byte beat, appended to expected_tokens
	task automatic lex_byte(input logic [7:0] b, input logic eos);
		logic [POSITION_BITS-1:0] p;
		logic [POSITION_BITS-1:0] prev;
		logic                     taken;
		logic [KIND_BITS-1:0]     pair;
		lexeme_t                  t;
		int                       i;
		p          = byte_pos;
		prev       = (p != '0) ? p - 1'b1 : '0;
		taken      = 1'b0;
		step_count = 0;
		if (held_op != PEND_NONE) begin
			if (b == CH_EQ) begin
				case (held_op)
					PEND_EQ: pair = KIND_EQEQ;
					PEND_GT: pair = KIND_GE;
					PEND_LT: pair = KIND_LE;
					default: pair = KIND_NE;
				endcase
				// only a confirmed '!=' ends the word the '!' trails
				if (held_op == PEND_BANG) flush_word();
				note_token(pair, prev, LENGTH_BITS'(2), 1'b0);
				held_op = PEND_NONE;
				taken   = 1'b1;
			end else begin
				resolve_held(prev);
			end
		end
		// inside a comment only the newline counts
		if (!taken && in_comment && b != CH_NL) taken = 1'b1;
		if (!taken) begin
			if (b == CH_NL) in_comment = 1'b0;
			case (b)
				CH_SPACE, CH_TAB, CH_NL, CH_EQ, CH_LPAREN, CH_RPAREN, CH_COLON, CH_LT,
				CH_GT, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_HASH: flush_word();
				default: ;
			endcase
			case (b)
				CH_HASH:   in_comment = 1'b1;
				CH_COLON:  note_token(KIND_COLON, p, LENGTH_BITS'(1), 1'b0);
				CH_LPAREN: note_token(KIND_LPAREN, p, LENGTH_BITS'(1), 1'b0);
				CH_RPAREN: note_token(KIND_RPAREN, p, LENGTH_BITS'(1), 1'b0);
				CH_PLUS:   note_token(KIND_PLUS, p, LENGTH_BITS'(1), 1'b0);
				CH_MINUS:  note_token(KIND_MINUS, p, LENGTH_BITS'(1), 1'b0);
				CH_STAR:   note_token(KIND_STAR, p, LENGTH_BITS'(1), 1'b0);
				CH_SLASH:  note_token(KIND_SLASH, p, LENGTH_BITS'(1), 1'b0);
				CH_EQ:     held_op = PEND_EQ;
				CH_LT:     held_op = PEND_LT;
				CH_GT:     held_op = PEND_GT;
				CH_BANG:   held_op = PEND_BANG;
				CH_NL: begin
					note_token(KIND_NEWLINE, p, LENGTH_BITS'(1), 1'b0);
					if (line_cnt != LINE_TOP) line_cnt = line_cnt + 1'b1;
				end
				CH_SPACE, CH_TAB: ;
				default: add_char(b, p);
			endcase
		end
		if (byte_pos != POS_TOP) byte_pos = byte_pos + 1'b1;
		// final byte: close what is open, report end of file, start over
		if (eos) begin
			resolve_held(p);
			flush_word();
			note_token(KIND_EOF, byte_pos, '0, 1'b0);
			clear_lexer();
		end
		for (i = 0; i < step_count; i++) begin
			t      = step_tokens[i];
			t.last = (i == step_count - 1);
			expected_tokens.insert(expected_tokens.size(), t);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, exp_val, act_val);
			fail_count++;
		end
	endtask

	task automatic add_byte(input logic [7:0] b);
		text_buf.insert(text_buf.size(), b);
	endtask

	task automatic add_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) add_byte(s[i]);
	endtask

	// move the built text into the beat queue, end of source on its last byte
	task automatic commit_text();
		int           i;
		source_beat_t beat;
		for (i = 0; i < text_buf.size(); i++) begin
			beat.data = text_buf[i];
			beat.eos  = (i == text_buf.size() - 1);
			source_beats.insert(source_beats.size(), beat);
		end
		text_buf.delete();
	endtask

	function automatic logic [7:0] word_char(input logic lead);
		int r;
		r = $urandom_range(0, lead ? 52 : 62);
		if (r < 26) word_char = CH_LA + 8'(r);
		else if (r < 52) word_char = CH_UA + 8'(r - 26);
		else if (r == 52) word_char = CH_USCORE;
		else word_char = CH_0 + 8'(r - 53);
	endfunction

	// one piece of plausible source text
	task automatic add_fragment();
		int         n;
		logic [7:0] rb;
		case ($urandom_range(0, 15))
			0, 1, 2: case ($urandom_range(0, 11))
				0: add_text("True");
				1: add_text("False");
				2: add_text("print");
				3: add_text("if");
				4: add_text("else");
				5: add_text("and");
				6: add_text("or");
				7: add_text("not");
				8: add_text("Tru");
				9: add_text("iff");
				10: add_text("printx");
				default: add_text("nota");
			endcase
			3, 4: begin
				add_byte(word_char(1'b1));
				repeat ($urandom_range(0, 6)) add_byte(word_char(1'b0));
			end
			5: repeat ($urandom_range(1, 4)) add_byte(CH_0 + 8'($urandom_range(0, 9)));
			6, 7, 8: case ($urandom_range(0, 15))
				0: add_text("=");
				1: add_text("==");
				2: add_text("<");
				3: add_text("<=");
				4: add_text(">");
				5: add_text(">=");
				6: add_text("!=");
				7: add_text("(");
				8: add_text(")");
				9: add_text(":");
				10: add_text("+");
				11: add_text("-");
				12: add_text("*");
				13: add_text("/");
				14: add_text("!");
				default: add_text("=<");
			endcase
			9: add_text(" ");
			10: add_text("\t");
			11: add_text("\n");
			12: begin
				// comment body may hold anything, operators and odd bytes too
				add_text("#");
				n = $urandom_range(0, 5);
				repeat (n) begin
					rb = 8'($urandom_range(0, 255));
					add_byte(rb);
				end
				add_text("\n");
			end
			13: begin
				rb = 8'($urandom_range(0, 255));
				add_byte(rb);
			end
			14: begin
				add_text("!");
				add_byte(word_char(1'b0));
			end
			default: add_text(" ");
		endcase
	endtask

	// sampling side: predict on each input beat, check each token beat, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			// predict first, so a token that leaves at once still finds its entry
			if (in_valid && in_ready) begin
				lex_byte(source_byte, end_of_source);
				in_beat_done = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (expected_tokens.size() == 0) begin
					$display("%0t: token beat expected none, actual kind %0d line %0d start %0d",
						$time, token_kind, line_number, start_offset);
					fail_count++;
				end else begin
					want = expected_tokens.pop_front();
					check_field("token_kind", 32'(want.tok.kind), 32'(token_kind));
					check_field("line_number", 32'(want.tok.line), 32'(line_number));
					check_field("start_offset", 32'(want.tok.start), 32'(start_offset));
					check_field("token_length", 32'(want.tok.length), 32'(token_length));
					check_field("word_overflow", 32'(want.tok.ovf), 32'(word_overflow));
					check_field("last_token", 32'(want.last), 32'(last_token));
				end
			end
			// watchdog on cycles with no beat on either channel
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("python_subset_lexer: mismatch");
					$finish;
				end
			end
		end
	end

	// driving side: a new byte beat only once the previous one is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_beat_done) begin
				if (source_beats.size() > 0 && (quiet || $urandom_range(0, 99) >= STALL_PCT)) begin
					next_beat = source_beats.pop_front();
					source_byte   <= next_beat.data;
					end_of_source <= next_beat.eos;
					in_valid      <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			in_beat_done = 1'b0;
			out_ready <= quiet || ($urandom_range(0, 99) >= STALL_PCT);
		end
	end

	initial begin
		int         random_bytes;
		int         i;
		logic [7:0] rb;
		random_bytes = 0;
		clear_lexer();

		// keyword, '!=' ending a word, comment with its newline, lone '!',
		// '<=', a word led by a non-ascii byte, a zero byte, '>' held at the end
		add_text("if a!=1#x\n(True)b!c<=9 ");
		add_byte(8'hFF);
		add_byte(8'h00);
		add_text(">");
		commit_text();

		// a word past the length counter, ended by the final byte itself
		add_byte(CH_LA);
		for (i = 1; i < LONG_WORD_LEN; i++) add_byte(word_char(1'b0));
		commit_text();

		// mostly well-formed lines, some raw byte noise
		while (random_bytes < RANDOM_BYTES) begin
			if ($urandom_range(0, 99) < 80) begin
				repeat ($urandom_range(2, 14)) begin
					add_fragment();
					if ($urandom_range(0, 2) == 0) add_text(" ");
				end
			end else begin
				repeat ($urandom_range(1, 8)) begin
					rb = 8'($urandom_range(0, 255));
					add_byte(rb);
				end
			end
			random_bytes += text_buf.size();
			commit_text();
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (source_beats.size() != 0 || in_valid) @(posedge clk);
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("python_subset_lexer: match");
		end else begin
			$display("python_subset_lexer: mismatch");
		end
		$finish;
	end

endmodule
